>>> rtl/mlsar_pkg.sv
// Shared types and constants of the multi-lane serial ADC reader.
`default_nettype none
package mlsar_pkg;

  localparam int LANE_CAP  = 4;
  localparam int DATA_BITS = 24;
  localparam int ADDR_W    = 3;

  localparam logic [DATA_BITS-1:0] SIGN_FLIP = 24'h800000;

  // Gain codes: the code sets how many extra clock pulses follow the data bits.
  localparam logic [1:0] GAIN_128 = 2'd0;
  localparam logic [1:0] GAIN_64  = 2'd1;
  localparam logic [1:0] GAIN_32  = 2'd2;

  // Register index, taken from the word address.
  localparam logic REG_GAIN_SELECT = 1'b0;

  typedef logic [DATA_BITS-1:0] sample_t;
  typedef sample_t [LANE_CAP-1:0] lane_bank_t;

  // What one tick produces before it is split into output beats.
  typedef struct packed {
    logic clock_level;
    logic emit;
  } step_res_t;

endpackage
`default_nettype wire

>>> rtl/mlsar_regs.sv
// Configuration register file with its APB-style access port.
`default_nettype none
module mlsar_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mlsar_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output logic [1:0]                       gain_select
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_select <= mlsar_pkg::GAIN_128;
    end else if (wr_en && paddr[2] == mlsar_pkg::REG_GAIN_SELECT
                 && pwdata[1:0] <= mlsar_pkg::GAIN_32) begin
      // The unused gain code is dropped and the old setting stays.
      gain_select <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == mlsar_pkg::REG_GAIN_SELECT) begin
      prdata = {30'd0, gain_select};
    end
  end

endmodule
`default_nettype wire

>>> rtl/mlsar_core.sv
// Readout sequencer: request latch, clock phase, bit and gain pulse counters, lane shifters.
`default_nettype none
module mlsar_core #(
  parameter int NUM_LANES = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic [3:0]             data,
  input  wire logic                   req,
  input  wire logic [1:0]             gain_select,
  output mlsar_pkg::step_res_t        res,
  output mlsar_pkg::lane_bank_t       lane_shift
);

  localparam int ACT = (NUM_LANES < 1) ? 1 :
                       (NUM_LANES > mlsar_pkg::LANE_CAP) ? mlsar_pkg::LANE_CAP : NUM_LANES;
  localparam logic [3:0] LANE_MASK = 4'((1 << ACT) - 1);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SHIFT = 2'd1,
    PH_GAIN  = 2'd2
  } phase_t;

  phase_t                phase, phase_next;
  logic [4:0]            bit_counter, bit_counter_next;
  logic [1:0]            gain_pulse_counter, gain_pulse_counter_next;
  logic                  request_pending, request_pending_next;
  logic                  clock_high, clock_high_next;
  mlsar_pkg::lane_bank_t lane_shift_next;
  logic [4:0]            bit_inc;
  logic [2:0]            gain_inc;
  logic                  pend;

  assign bit_inc  = bit_counter + 5'd1;
  assign gain_inc = {1'b0, gain_pulse_counter} + 3'd1;
  assign pend     = request_pending | req;

  always_comb begin
    phase_next              = phase;
    bit_counter_next        = bit_counter;
    gain_pulse_counter_next = gain_pulse_counter;
    request_pending_next    = pend;
    clock_high_next         = clock_high;
    lane_shift_next         = lane_shift;
    res.clock_level         = 1'b0;
    res.emit                = 1'b0;
    unique case (phase)
      PH_SHIFT: begin
        if (clock_high) begin
          clock_high_next = 1'b0;
          res.clock_level = 1'b1;
        end else begin
          for (int i = 0; i < ACT; i++) begin
            lane_shift_next[i] = {lane_shift[i][mlsar_pkg::DATA_BITS-2:0], data[i]};
          end
          bit_counter_next = bit_inc;
          clock_high_next  = 1'b1;
          if (bit_inc >= 5'(mlsar_pkg::DATA_BITS)) begin
            phase_next              = PH_GAIN;
            gain_pulse_counter_next = 2'd0;
          end
        end
      end
      PH_GAIN: begin
        if (clock_high) begin
          clock_high_next = 1'b0;
          res.clock_level = 1'b1;
        end else begin
          gain_pulse_counter_next = gain_inc[1:0];
          clock_high_next         = 1'b1;
          if (gain_inc >= {1'b0, gain_select} + 3'd1) begin
            // Last gain pulse done: the samples go out on this low tick.
            phase_next              = PH_IDLE;
            bit_counter_next        = 5'd0;
            gain_pulse_counter_next = 2'd0;
            clock_high_next         = 1'b0;
            res.emit                = 1'b1;
          end
        end
      end
      default: begin
        // Idle, and the unused phase code, which falls back to idle.
        phase_next = PH_IDLE;
        if (pend && (data & LANE_MASK) == 4'd0) begin
          request_pending_next    = 1'b0;
          phase_next              = PH_SHIFT;
          bit_counter_next        = 5'd0;
          gain_pulse_counter_next = 2'd0;
          clock_high_next         = 1'b1;
          lane_shift_next         = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      bit_counter        <= 5'd0;
      gain_pulse_counter <= 2'd0;
      request_pending    <= 1'b0;
      clock_high         <= 1'b0;
      lane_shift         <= '0;
    end else if (step) begin
      phase              <= phase_next;
      bit_counter        <= bit_counter_next;
      gain_pulse_counter <= gain_pulse_counter_next;
      request_pending    <= request_pending_next;
      clock_high         <= clock_high_next;
      lane_shift         <= lane_shift_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/mlsar_out.sv
// Result register that turns one tick into one beat, or one beat per lane when samples go out.
`default_nettype none
module mlsar_out #(
  parameter int NUM_LANES = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire mlsar_pkg::step_res_t   res,
  input  wire mlsar_pkg::lane_bank_t  lane_shift,
  output logic                        free,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        clock_level,
  output logic                        sample_valid,
  output logic [1:0]                  lane_index,
  output logic [23:0]                 sample_value,
  output logic                        last_of_run
);

  localparam int ACT = (NUM_LANES < 1) ? 1 :
                       (NUM_LANES > mlsar_pkg::LANE_CAP) ? mlsar_pkg::LANE_CAP : NUM_LANES;
  localparam logic [1:0] LAST_IDX = 2'(ACT - 1);

  logic       clk_lvl;
  logic       emit;
  logic [1:0] idx;
  logic       last;

  assign last = !emit || idx == LAST_IDX;
  assign free = !out_valid || (!out_stall && last);

  // The lane shifters hold still while samples go out, since no tick is
  // taken until the last beat of the run has left.
  assign clock_level  = clk_lvl;
  assign sample_valid = emit;
  assign lane_index   = emit ? idx : 2'd0;
  assign sample_value = emit ? (lane_shift[idx] ^ mlsar_pkg::SIGN_FLIP) : 24'd0;
  assign last_of_run  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      emit      <= 1'b0;
      idx       <= 2'd0;
      clk_lvl   <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      emit      <= res.emit;
      clk_lvl   <= res.clock_level;
      idx       <= 2'd0;
    end else if (out_valid && !out_stall) begin
      if (last) begin
        out_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/multi_lane_serial_adc_reader.sv
// Top level of the multi-lane serial ADC reader: input register, sequencer, result stage.
//
// Each input beat is one half-period tick of the shared ADC serial clock and
// carries the sampled data lines of every lane and a conversion request.
// A request is latched; once it is pending and all active data lines are low,
// the block drives the serial clock, shifting one bit per lane on each low
// tick until all data bits are in, then the gain pulses set by gain_select (APB register 0).
// Every tick gives one output beat carrying the clock level for that tick.
// The tick that ends the gain pulses instead gives one beat per active lane,
// sample_valid high, the sample in offset binary, last_of_run on the last lane.
// An accepted input beat passes the input register, then the result register.
// One tick is taken per cycle while the result stage is free; a sample tick
// holds the result stage until every active lane has gone out, and the input stalls meanwhile.
// A stall on the output holds the result register and backs up into the
// input register, after which in_stall rises.
// Reset clears the sequencer to idle with no pending request, zeroes the
// lane shifters and sets the gain to 128.
`default_nettype none
module multi_lane_serial_adc_reader #(
  parameter int NUM_LANES = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [3:0]                   data_lines,
  input  wire logic                         convert_request,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              clock_level,
  output logic                              sample_valid,
  output logic [1:0]                        lane_index,
  output logic [23:0]                       sample_value,
  output logic                              last_of_run,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mlsar_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int ACT = (NUM_LANES < 1) ? 1 :
                       (NUM_LANES > mlsar_pkg::LANE_CAP) ? mlsar_pkg::LANE_CAP : NUM_LANES;

  logic                  in_full;
  logic [3:0]            in_data;
  logic                  in_req;
  logic                  free;
  logic                  move;
  logic [1:0]            gain_select;
  mlsar_pkg::step_res_t  res;
  mlsar_pkg::lane_bank_t lane_shift;

  assign move     = in_full && free;
  assign in_stall = in_full && !move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data <= data_lines;
      in_req  <= convert_request;
    end
  end

  mlsar_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .gain_select (gain_select)
  );

  mlsar_core #(.NUM_LANES(NUM_LANES)) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (move),
    .data        (in_data),
    .req         (in_req),
    .gain_select (gain_select),
    .res         (res),
    .lane_shift  (lane_shift)
  );

  mlsar_out #(.NUM_LANES(NUM_LANES)) u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (move),
    .res          (res),
    .lane_shift   (lane_shift),
    .free         (free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .clock_level  (clock_level),
    .sample_valid (sample_valid),
    .lane_index   (lane_index),
    .sample_value (sample_value),
    .last_of_run  (last_of_run)
  );

  a_sample_clock_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_valid |-> !clock_level)
    else $error("sample beat with the serial clock high");

  a_tick_single_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_valid |-> last_of_run)
    else $error("clock-only beat not marked last");

  a_last_lane: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_valid && last_of_run |-> lane_index == 2'(ACT - 1))
    else $error("run ended on the wrong lane");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full && out_valid)
    else $error("input stalled with room to move");

endmodule
`default_nettype wire
